@@ design/crc16_packet_framer_assert.svh @@
// assertion macros for the crc16 packet framer checker
`ifndef CRC16_PACKET_FRAMER_ASSERT_SVH
`define CRC16_PACKET_FRAMER_ASSERT_SVH

// clocked property, ignored while reset is high
`define CRCPF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define CRCPF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/crcpf_pkg.sv @@
// shared types, constants and crc function for the crc16 packet framer
`timescale 1ns / 1ps
`default_nettype none
package crcpf_pkg;

  localparam int SYNC_LENGTH_DEF = 8;
  localparam int CMDQ_DEPTH      = 2;
  localparam int OUTQ_DEPTH      = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC     = 1'd1;

  localparam logic [63:0] PREAMBLE_RESET = 64'h5339_14DD_1C49_3412;
  localparam logic [7:0]  SYNC_RESET     = 8'h55;
  localparam logic [7:0]  SEPARATOR_BYTE = 8'hFF;
  localparam logic [15:0] CRC_INIT       = 16'hFFFE;

  // byte offsets counted from the first preamble byte
  localparam logic [4:0] OFS_ID_HI  = 5'd8;
  localparam logic [4:0] OFS_ID_MID = 5'd9;
  localparam logic [4:0] OFS_ID_LO  = 5'd10;
  localparam logic [4:0] OFS_SEP    = 5'd11;
  localparam logic [4:0] OFS_SEQ    = 5'd12;
  localparam logic [4:0] OFS_CMD    = 5'd13;
  localparam logic [4:0] OFS_ARG    = 5'd14;
  localparam logic [4:0] OFS_CRC_HI = 5'd15;
  localparam logic [4:0] OFS_CRC_LO = 5'd16;

  typedef struct packed {
    logic [23:0] sender_id;
    logic [7:0]  command_code;
    logic [7:0]  command_argument;
  } in_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [23:0] sender_id;
    logic [7:0]  command_code;
    logic [7:0]  command_argument;
    logic [7:0]  sequence_num;
  } cmd_t;

  // byte-wise ccitt crc step, no reflection
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'd0, x[7:4]};
    return {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
  endfunction

endpackage
`default_nettype wire

@@ design/crcpf_front.sv @@
// front end: accepts commands and tags them with the sequence number
`timescale 1ns / 1ps
`default_nettype none
module crcpf_front
  import crcpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  cmd,
  output logic full,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_data
);

  logic [7:0] sequence_count;

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_comb begin
    q_data.sender_id        = cmd.sender_id;
    q_data.command_code     = cmd.command_code;
    q_data.command_argument = cmd.command_argument;
    q_data.sequence_num     = sequence_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count <= 8'd0;
    end else if (q_push) begin
      sequence_count <= sequence_count + 8'd1;
    end
  end

endmodule
`default_nettype wire

@@ design/crcpf_cmd_fifo.sv @@
// short command queue between front end and byte sequencer
`timescale 1ns / 1ps
`default_nettype none
module crcpf_cmd_fifo
  import crcpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMDQ_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMDQ_DEPTH);

  cmd_t             mem [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/crcpf_back.sv @@
// back end: byte sequencer, running crc, config registers and result queue
`timescale 1ns / 1ps
`default_nettype none
module crcpf_back
  import crcpf_pkg::*;
#(
  parameter int SYNC_LENGTH = SYNC_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_empty,
  input  cmd_t                  q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  result
);

  localparam int POS_W = $clog2(SYNC_LENGTH + 17);
  localparam logic [POS_W-1:0] SYNC_POS = POS_W'(SYNC_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SYNC_LENGTH + 16);
  localparam int OPTR_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
  localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam logic [OPTR_W-1:0] OPTR_LAST = OPTR_W'(OUTQ_DEPTH - 1);
  localparam logic [OCNT_W-1:0] OCNT_FULL = OCNT_W'(OUTQ_DEPTH);

  logic [63:0]       preamble_word;
  logic [7:0]        sync_byte;

  logic              active;
  logic [POS_W-1:0]  byte_position;
  logic [15:0]       crc_running;
  cmd_t              held_fields;

  out_t              outq [OUTQ_DEPTH];
  logic [OPTR_W-1:0] owr_ptr;
  logic [OPTR_W-1:0] ord_ptr;
  logic [OCNT_W-1:0] ocount;

  logic              gen;
  logic              pop_acc;
  logic              in_payload;
  logic [POS_W-1:0]  ofs_full;
  logic [4:0]        ofs;
  out_t              gen_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_word <= PREAMBLE_RESET;
      sync_byte     <= SYNC_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PREAMBLE: preamble_word <= cfg_data;
        REG_SYNC:     sync_byte     <= cfg_data[7:0];
        default:      ;
      endcase
    end
  end

  assign pop_acc = pop && !empty;
  assign gen     = active && (ocount != OCNT_FULL);
  assign q_pop   = !q_empty && (!active || (gen && byte_position == LAST_POS));

  assign in_payload = (byte_position >= SYNC_POS);
  assign ofs_full   = byte_position - SYNC_POS;
  assign ofs        = ofs_full[4:0];

  // pick the byte for the current packet position
  always_comb begin
    gen_word.last_byte   = 1'b0;
    gen_word.packet_byte = sync_byte;
    if (in_payload) begin
      case (ofs)
        OFS_ID_HI:  gen_word.packet_byte = held_fields.sender_id[23:16];
        OFS_ID_MID: gen_word.packet_byte = held_fields.sender_id[15:8];
        OFS_ID_LO:  gen_word.packet_byte = held_fields.sender_id[7:0];
        OFS_SEP:    gen_word.packet_byte = SEPARATOR_BYTE;
        OFS_SEQ:    gen_word.packet_byte = held_fields.sequence_num;
        OFS_CMD:    gen_word.packet_byte = held_fields.command_code;
        OFS_ARG:    gen_word.packet_byte = held_fields.command_argument;
        OFS_CRC_HI: gen_word.packet_byte = crc_running[15:8];
        OFS_CRC_LO: begin
          gen_word.packet_byte = crc_running[7:0];
          gen_word.last_byte   = 1'b1;
        end
        default:    gen_word.packet_byte = preamble_word[{~ofs[2:0], 3'b000} +: 8];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      held_fields <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      byte_position <= '0;
      crc_running   <= CRC_INIT;
    end else if (q_pop) begin
      active        <= 1'b1;
      byte_position <= '0;
      crc_running   <= CRC_INIT;
    end else if (gen) begin
      if (byte_position == LAST_POS) begin
        active        <= 1'b0;
        byte_position <= '0;
        crc_running   <= CRC_INIT;
      end else begin
        byte_position <= byte_position + POS_W'(1);
        // crc covers the preamble through the argument byte
        if (in_payload && ofs < OFS_CRC_HI) begin
          crc_running <= crc_update(crc_running, gen_word.packet_byte);
        end
      end
    end
  end

  // result queue parts the sequencer from the consumer
  assign empty  = (ocount == '0);
  assign result = outq[ord_ptr];

  always_ff @(posedge clk) begin
    if (gen) begin
      outq[owr_ptr] <= gen_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (gen) begin
        owr_ptr <= (owr_ptr == OPTR_LAST) ? '0 : owr_ptr + OPTR_W'(1);
      end
      if (pop_acc) begin
        ord_ptr <= (ord_ptr == OPTR_LAST) ? '0 : ord_ptr + OPTR_W'(1);
      end
      if (gen && !pop_acc) begin
        ocount <= ocount + OCNT_W'(1);
      end else if (pop_acc && !gen) begin
        ocount <= ocount - OCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ design/crc16_packet_framer.sv @@
// top level of the crc16 packet framer
// a command waits in the command queue, then the sequencer, then the result queue
// throughput: SYNC_LENGTH + 17 bytes per command (25 by default), one byte per cycle
//   if the result queue has room, paced by the back-end byte sequencer; no packet gap
// reset: sequence number 0, preamble and sync registers to defaults, all queues empty
`timescale 1ns / 1ps
`default_nettype none
module crc16_packet_framer
  import crcpf_pkg::*;
#(
  parameter int SYNC_LENGTH = SYNC_LENGTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_t                   cmd,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_t                  result,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic q_full;
  logic q_push;
  cmd_t q_wr_data;
  logic q_pop;
  cmd_t q_rd_data;
  logic q_empty;

  crcpf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd    (cmd),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  crcpf_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  crcpf_back #(
    .SYNC_LENGTH (SYNC_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

@@ design/crcpf_checker.sv @@
// port-level checker for the crc16 packet framer and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_packet_framer_assert.svh"
module crcpf_checker
  import crcpf_pkg::*;
#(
  parameter int SYNC_LENGTH = SYNC_LENGTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t result
);

  localparam int BCNT_W = $clog2(SYNC_LENGTH + 17);
  localparam logic [BCNT_W-1:0] LAST_COUNT = BCNT_W'(SYNC_LENGTH + 16);

  logic              push_acc;
  logic              pop_acc;
  logic              last_acc;
  logic [3:0]        pending;
  logic [BCNT_W-1:0] byte_count;

  assign push_acc = push && !full;
  assign pop_acc  = pop && !empty;
  assign last_acc = pop_acc && result.last_byte;

  // packets accepted whose last word has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 4'd0;
    end else if (push_acc && !last_acc) begin
      pending <= pending + 4'd1;
    end else if (last_acc && !push_acc) begin
      pending <= pending - 4'd1;
    end
  end

  // words taken since the last packet end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (last_acc) begin
      byte_count <= '0;
    end else if (pop_acc) begin
      byte_count <= byte_count + BCNT_W'(1);
    end
  end

  `CRCPF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result queue not empty after reset")
  `CRCPF_ASSERT(a_no_phantom, clk, rst, !empty |-> pending != 4'd0, "word without a command")
  `CRCPF_ASSERT(a_packet_length, clk, rst, last_acc |-> byte_count == LAST_COUNT, "bad packet length")
  `CRCPF_ASSERT(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "word not held")

endmodule

bind crc16_packet_framer crcpf_checker #(.SYNC_LENGTH(SYNC_LENGTH)) u_checker (.*);
`default_nettype wire
